// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- hw/rtl/saw_pkg.sv -----
`timescale 1ns / 1ps

package saw_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned HIST_DEPTH = 6;

   localparam logic [BYTE_W-1:0] SYNC_LEAD = 8'hFF;
   localparam logic [BYTE_W-1:0] SYNC_LAST = 8'hAA;

   localparam logic [1:0] LAST_POS = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SYNC   = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   typedef struct packed {
      logic              word_valid;
      logic [WORD_W-1:0] out_word;
      logic              stream_done;
      status_type        status;
   } rsp_type;

endpackage

// ----- hw/rtl/saw_core.sv -----
`timescale 1ns / 1ps

module saw_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [saw_pkg::BYTE_W-1:0] data_byte,
   input  logic                      end_of_file,
   output logic                      has_result,
   output saw_pkg::rsp_type          result
);
   import saw_pkg::*;

   logic [BYTE_W-1:0] hist_ff [HIST_DEPTH];
   logic [BYTE_W-1:0] hist_in [HIST_DEPTH];
   logic [1:0]        pos_ff, pos_in;
   logic              found_ff, found_in;

   logic              match;
   logic              emit;
   logic              found_now;
   logic [WORD_W-1:0] word;
   status_type        status;

   assign match = !found_ff && (data_byte == SYNC_LAST) && (hist_ff[0] == SYNC_LEAD)
                  && (hist_ff[1] == SYNC_LEAD) && (hist_ff[2] == SYNC_LEAD);
   assign emit       = (found_ff && (pos_ff == LAST_POS)) || match;
   assign found_now  = found_ff || match;
   assign has_result = emit || end_of_file;

   // group alignment of the packed word
   always_comb begin
      if (found_ff) begin
         word = {hist_ff[2], hist_ff[1], hist_ff[0], data_byte};
      end else begin
         case (pos_ff)
            2'd0:    word = {hist_ff[3], hist_ff[2], hist_ff[1], hist_ff[0]};
            2'd1:    word = {hist_ff[4], hist_ff[3], hist_ff[2], hist_ff[1]};
            2'd2:    word = {hist_ff[5], hist_ff[4], hist_ff[3], hist_ff[2]};
            default: word = {hist_ff[2], hist_ff[1], hist_ff[0], data_byte};
         endcase
      end
   end

   always_comb begin
      if (!end_of_file) begin
         status = STATUS_OK;
      end else if (!found_now) begin
         status = STATUS_NO_SYNC;
      end else if (pos_ff != LAST_POS) begin
         status = STATUS_TRUNCATED;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      result.word_valid  = emit;
      result.out_word    = emit ? word : '0;
      result.stream_done = end_of_file;
      result.status      = status;
   end

   always_comb begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      pos_in   = pos_ff;
      found_in = found_ff;
      if (fire) begin
         if (end_of_file) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
               hist_in[i] = '0;
            end
            pos_in   = '0;
            found_in = 1'b0;
         end else begin
            for (int i = 1; i < HIST_DEPTH; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            hist_in[0] = data_byte;
            pos_in     = pos_ff + 2'd1;
            found_in   = found_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         hist_ff  <= hist_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
   end

endmodule

// ----- hw/rtl/saw_out_reg.sv -----
`timescale 1ns / 1ps

module saw_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  saw_pkg::rsp_type result,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic             out_free,
   output saw_pkg::rsp_type rsp_data
);
   import saw_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hw/rtl/sync_align_word_swapper.sv -----
// path: a byte accepted is held in the input register, and its result, if any, is
//   loaded into the output register when the core advances on that byte
// throughput: one byte per cycle while rsp_ready does not stall the output; the output register takes a new result
//   in the same cycle that the old one is transferred
// reset: synchronous, active high; clears history, group position,
//   sync flag and both valid stages
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sync_align_word_swapper (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [saw_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_end_of_file,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_word_valid,
   output logic [saw_pkg::WORD_W-1:0] rsp_out_word,
   output logic                       rsp_stream_done,
   output logic [1:0]                 rsp_status
);
   import saw_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_eof_ff, in_eof_in;

   logic    has_result;
   logic    out_free;
   logic    advance;
   rsp_type result;
   rsp_type rsp_data;

   logic              in_stall;
   logic [BYTE_W:0]   in_held;
   logic              status_set;

   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eof_in   = in_eof_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_eof_in   = req_end_of_file;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_eof_ff  <= in_eof_in;
   end

   saw_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .data_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .has_result  (has_result),
      .result      (result)
   );

   saw_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && has_result),
      .result    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .out_free  (out_free),
      .rsp_data  (rsp_data)
   );

   assign rsp_word_valid  = rsp_data.word_valid;
   assign rsp_out_word    = rsp_data.out_word;
   assign rsp_stream_done = rsp_data.stream_done;
   assign rsp_status      = rsp_data.status;

   assign in_stall   = in_valid_ff && !advance;
   assign in_held    = {in_byte_ff, in_eof_ff};
   assign status_set = (rsp_status != STATUS_OK);

   `ASSERT_PROP(a_held_byte_stable, clock, reset, in_stall |=> in_valid_ff && $stable(in_held))
   `ASSERT_NEVER(a_empty_result, clock, reset, rsp_valid && !rsp_word_valid && !rsp_stream_done)
   `ASSERT_NEVER(a_status_without_done, clock, reset, rsp_valid && !rsp_stream_done && status_set)

endmodule
